// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the program stream demux RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/psd_pkg.sv -----
// Package for the program stream PES demux: widths, phase codes, result kinds.
// No dependencies.
package psd_pkg;
  localparam int PosBits = 48;
  localparam int MaxPayload = 65535;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_PROBE = 2'd2;

  localparam logic [3:0] PH_HUNT = 4'd0;
  localparam logic [3:0] PH_SKIP = 4'd1;
  localparam logic [3:0] PH_OOB_HI = 4'd2;
  localparam logic [3:0] PH_OOB_LO = 4'd3;
  localparam logic [3:0] PH_LEN_HI = 4'd4;
  localparam logic [3:0] PH_LEN_LO = 4'd5;
  localparam logic [3:0] PH_STUFF = 4'd6;
  localparam logic [3:0] PH_STD1 = 4'd7;
  localparam logic [3:0] PH_STD2 = 4'd8;
  localparam logic [3:0] PH_M2_FLAGS = 4'd9;
  localparam logic [3:0] PH_M2_HLEN = 4'd10;
  localparam logic [3:0] PH_STAMP = 4'd11;
  localparam logic [3:0] PH_HSKIP = 4'd12;
  localparam logic [3:0] PH_SUBID = 4'd13;
  localparam logic [3:0] PH_TAIL = 4'd14;
  localparam logic [3:0] PH_PAYLOAD = 4'd15;

  localparam logic REG_SELECTED = 1'b0;
  localparam logic REG_PROBE = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [15:0] stream_code;
    logic is_selected;
    logic [15:0] payload_length;
    logic has_pts;
    logic [32:0] pts;
    logic has_dts;
    logic [32:0] dts;
    logic [PosBits-1:0] packet_offset;
    logic last_of_packet;
  } result_t;
endpackage

// ----- hw/rtl/psd_if.sv -----
// Stream channel interfaces: byte input, result output, config writes.
// Depends on psd_pkg.
interface psd_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface psd_out_if import psd_pkg::*;;
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psd_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [47:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

// ----- hw/rtl/program_stream_pes_demux_unit.sv -----
// Program stream PES demux: one byte per cycle, at most one result per byte.
// A result is registered and valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the output register stalls input only when full
// and not being drained. Parse state updates in the cycle the byte is taken.
// Synchronous active-high reset restores registers and parse state; after a
// probe-limit stop, bytes are swallowed until reset.
`include "assert_macros.svh"
module program_stream_pes_demux_unit import psd_pkg::*; (
  input logic clk,
  input logic rst,
  psd_in_if.sink in_ch,
  psd_out_if.source out_ch,
  psd_cfg_if.sink cfg
);
  localparam logic [16:0] NegSize = 17'h10000;

  logic [15:0] selected_stream;
  logic [PosBits-1:0] probe_limit;
  logic [23:0] hunt_window;
  logic [PosBits-1:0] byte_position;
  logic [3:0] parse_phase;
  logic [15:0] skip_count;
  logic [16:0] size_left;
  logic [7:0] header_left;
  logic [32:0] pts_accum, dts_accum;
  logic [7:0] current_id, sub_id;
  logic [PosBits-1:0] start_position;
  logic stopped, stamp_m1, stamp_m0, is_mpeg1, got_pts, got_dts, sel_flag;
  logic [3:0] stamp_total;

  logic [23:0] hunt_window_next;
  logic [3:0] parse_phase_next;
  logic [15:0] skip_count_next;
  logic [16:0] size_left_next;
  logic [7:0] header_left_next, current_id_next, sub_id_next;
  logic [32:0] pts_accum_next, dts_accum_next;
  logic [PosBits-1:0] start_position_next, pos_inc;
  logic stopped_next, m1_next, m0_next, is_mpeg1_next, got_pts_next, got_dts_next;
  logic sel_flag_next;
  logic [3:0] stamp_total_next;
  logic res_valid;
  result_t res;

  logic take, out_full;
  logic [7:0] b;
  logic [16:0] sub_amt, sz;
  logic sub_en;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_full || out_ch.ready;
  assign cfg.ready = 1'b1;
  assign b = in_ch.data_byte;
  assign pos_inc = byte_position + 1'b1;

  function automatic logic [32:0] stamp_part(input logic [3:0] j, input logic [7:0] v);
    case (j)
      4'd0: stamp_part = {v[3:1], 30'd0};
      4'd1: stamp_part = {3'd0, v, 22'd0};
      4'd2: stamp_part = {11'd0, v[7:1], 15'd0};
      4'd3: stamp_part = {18'd0, v, 7'd0};
      default: stamp_part = {26'd0, v[7:1]};
    endcase
  endfunction

  always_comb begin
    logic [15:0] code;
    logic [7:0] s;
    logic [2:0] extra;
    logic [3:0] m;
    logic do_finish, do_tail, do_end, do_m1;
    logic [3:0] j;
    hunt_window_next = hunt_window;
    parse_phase_next = parse_phase;
    skip_count_next = skip_count;
    header_left_next = header_left;
    pts_accum_next = pts_accum;
    dts_accum_next = dts_accum;
    current_id_next = current_id;
    sub_id_next = sub_id;
    start_position_next = start_position;
    stopped_next = stopped;
    m1_next = stamp_m1;
    m0_next = stamp_m0;
    is_mpeg1_next = is_mpeg1;
    got_pts_next = got_pts;
    got_dts_next = got_dts;
    sel_flag_next = sel_flag;
    stamp_total_next = stamp_total;
    sub_en = 1'b0;
    sub_amt = '0;
    sz = size_left;
    res_valid = 1'b0;
    res = '0;
    do_finish = 1'b0;
    do_tail = 1'b0;
    do_end = 1'b0;
    do_m1 = 1'b0;
    s = b;
    extra = 3'd0;
    m = b[7:4];
    j = 4'd0;
    code = '0;
    case (parse_phase)
      PH_HUNT: begin
        if (hunt_window != 24'h000001) begin
          hunt_window_next = {hunt_window[15:0], b};
        end else begin
          hunt_window_next = '1;
          if (probe_limit != '0 && pos_inc > probe_limit) begin
            stopped_next = 1'b1;
            res_valid = 1'b1;
            res.kind = KIND_PROBE;
          end else begin
            current_id_next = b;
            start_position_next = pos_inc - PosBits'(4);
            if (b == 8'hBA) begin
              skip_count_next = 16'd8;
              parse_phase_next = PH_SKIP;
            end else if (b == 8'hBE || b == 8'hBB) begin
              parse_phase_next = PH_OOB_HI;
            end else if ((b >= 8'hC0 && b < 8'hC9) || (b >= 8'hE0 && b < 8'hE9) ||
                         (b >= 8'h20 && b < 8'h29) || b == 8'hBD || b == 8'hBF) begin
              sub_id_next = 8'hFF;
              pts_accum_next = '0;
              dts_accum_next = '0;
              got_pts_next = 1'b0;
              got_dts_next = 1'b0;
              is_mpeg1_next = 1'b0;
              header_left_next = '0;
              parse_phase_next = PH_LEN_HI;
            end
          end
        end
      end
      PH_SKIP: begin
        if (skip_count <= 16'd1) begin
          skip_count_next = '0;
          parse_phase_next = PH_HUNT;
          hunt_window_next = '1;
        end else begin
          skip_count_next = skip_count - 1'b1;
        end
      end
      PH_OOB_HI: begin
        skip_count_next = {b, 8'd0};
        parse_phase_next = PH_OOB_LO;
      end
      PH_OOB_LO: begin
        skip_count_next = {skip_count[15:8], b};
        if ({skip_count[15:8], b} == 16'd0) begin
          parse_phase_next = PH_HUNT;
          hunt_window_next = '1;
        end else begin
          parse_phase_next = PH_SKIP;
        end
      end
      PH_LEN_HI: begin
        sz = {1'b0, b, 8'd0};
        parse_phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        sz = {size_left[16:8], b};
        if (current_id == 8'hBF) do_finish = 1'b1;
        else parse_phase_next = PH_STUFF;
      end
      PH_STUFF: begin
        if (b == 8'hFF) begin
          sub_en = 1'b1;
          sub_amt = 17'd1;
        end else if (b[7:6] == 2'b10) begin
          parse_phase_next = PH_M2_FLAGS;
        end else begin
          is_mpeg1_next = 1'b1;
          if (b[7:6] == 2'b01) begin
            sub_en = 1'b1;
            sub_amt = 17'd2;
            parse_phase_next = PH_STD1;
          end else begin
            do_m1 = 1'b1;
          end
        end
      end
      PH_STD1: parse_phase_next = PH_STD2;
      PH_STD2: do_m1 = 1'b1;
      PH_M2_FLAGS: begin
        m1_next = b[7];
        m0_next = b[6];
        parse_phase_next = PH_M2_HLEN;
      end
      PH_M2_HLEN: begin
        sub_en = 1'b1;
        sub_amt = 17'd3 + 17'(b);
        if (!stamp_m1 && stamp_m0) begin
          parse_phase_next = PH_HUNT;
          hunt_window_next = '1;
        end else if (stamp_m1 && !stamp_m0 && b >= 8'd5) begin
          stamp_total_next = 4'd5;
          header_left_next = b - 8'd5;
          skip_count_next = '0;
          parse_phase_next = PH_STAMP;
        end else if (stamp_m1 && stamp_m0 && b >= 8'd10) begin
          stamp_total_next = 4'd10;
          header_left_next = b - 8'd10;
          skip_count_next = '0;
          parse_phase_next = PH_STAMP;
        end else begin
          header_left_next = b;
          do_tail = 1'b1;
        end
      end
      PH_STAMP: begin
        if (skip_count[3:0] < 4'd5) begin
          pts_accum_next = pts_accum | stamp_part(skip_count[3:0], b);
        end else begin
          j = skip_count[3:0] - 4'd5;
          dts_accum_next = dts_accum | stamp_part(j, b);
        end
        skip_count_next = skip_count + 1'b1;
        if (skip_count[3:0] + 4'd1 >= stamp_total) begin
          got_pts_next = 1'b1;
          got_dts_next = (stamp_total == 4'd10);
          skip_count_next = '0;
          do_tail = 1'b1;
        end
      end
      PH_HSKIP: begin
        header_left_next = (header_left > 8'd0) ? header_left - 8'd1 : 8'd0;
        if (header_left <= 8'd1) do_end = 1'b1;
      end
      PH_SUBID: begin
        if (b >= 8'h88 && b <= 8'h8B) s = b - 8'h48;
        else if (b >= 8'h80 && b <= 8'h87) s = b - 8'h80;
        else if (b >= 8'hA0 && b <= 8'hA7) extra = 3'd3;
        else if (!(b >= 8'h20 && b <= 8'h27)) s = 8'hFF;
        if (s > 8'h26 || s < 8'h20) extra = extra + 3'd3;
        sub_en = 1'b1;
        sub_amt = 17'(extra) + 17'd1;
        sub_id_next = s;
        if (extra == 3'd0) begin
          do_finish = 1'b1;
        end else begin
          skip_count_next = 16'(extra);
          parse_phase_next = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (skip_count <= 16'd1) begin
          skip_count_next = '0;
          do_finish = 1'b1;
        end else begin
          skip_count_next = skip_count - 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (size_left > 17'd0) sz = size_left - 17'd1;
        if (sz == 17'd0) begin
          parse_phase_next = PH_HUNT;
          hunt_window_next = '1;
        end
        if (sel_flag) begin
          res_valid = 1'b1;
          res.kind = KIND_PAYLOAD;
          res.payload_byte = b;
          res.last_of_packet = (sz == 17'd0);
        end
      end
      default: begin
        parse_phase_next = PH_HUNT;
        hunt_window_next = '1;
      end
    endcase

    if (do_m1) begin
      if (m == 4'd1) begin
        parse_phase_next = PH_HUNT;
        hunt_window_next = '1;
      end else if (m == 4'd2 || m == 4'd3) begin
        sub_en = 1'b1;
        sub_amt = (m == 4'd2) ? 17'd4 : 17'd9;
        pts_accum_next = {b[3:1], 30'd0};
        stamp_total_next = 4'd5;
        skip_count_next = 16'd1;
        header_left_next = (m == 4'd3) ? 8'd5 : 8'd0;
        parse_phase_next = PH_STAMP;
      end else begin
        header_left_next = '0;
        do_end = 1'b1;
      end
    end

    // size deduction
    if (sub_en && !size_left[16]) begin
      sz = (sub_amt > size_left) ? NegSize : size_left - sub_amt;
    end

    if (do_tail) begin
      if (header_left_next != 8'd0) parse_phase_next = PH_HSKIP;
      else do_end = 1'b1;
    end
    if (do_end) begin
      if (is_mpeg1_next) begin
        if (!sz[16]) sz = (sz == 17'd0) ? NegSize : sz - 17'd1;
        do_finish = 1'b1;
      end else if (current_id == 8'hBD && (sz[16] || sz > 17'd5)) begin
        parse_phase_next = PH_SUBID;
      end else begin
        do_finish = 1'b1;
      end
    end
    if (do_finish) begin
      if (sz[16] || sz == 17'd0 || sz > 17'(MaxPayload)) begin
        parse_phase_next = PH_HUNT;
        hunt_window_next = '1;
      end else begin
        code = (current_id == 8'hBD) ? {8'hFF, sub_id_next} : {8'd0, current_id};
        sel_flag_next = (code == selected_stream);
        res_valid = 1'b1;
        res.kind = KIND_HEADER;
        res.stream_code = code;
        res.is_selected = (code == selected_stream);
        res.payload_length = sz[15:0];
        res.has_pts = got_pts_next;
        res.pts = got_pts_next ? pts_accum_next : '0;
        res.has_dts = got_dts_next;
        res.dts = got_dts_next ? dts_accum_next : '0;
        res.packet_offset = start_position;
        parse_phase_next = PH_PAYLOAD;
      end
    end
    size_left_next = sz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_stream <= 16'h00E0;
      probe_limit <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        {1'b0, REG_SELECTED}: selected_stream <= cfg.value[15:0];
        {1'b0, REG_PROBE}: probe_limit <= cfg.value[PosBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_window <= '1;
      byte_position <= '0;
      parse_phase <= PH_HUNT;
      skip_count <= '0;
      size_left <= '0;
      header_left <= '0;
      pts_accum <= '0;
      dts_accum <= '0;
      current_id <= '0;
      sub_id <= 8'hFF;
      start_position <= '0;
      stopped <= 1'b0;
      stamp_m1 <= 1'b0;
      stamp_m0 <= 1'b0;
      stamp_total <= '0;
      is_mpeg1 <= 1'b0;
      got_pts <= 1'b0;
      got_dts <= 1'b0;
      sel_flag <= 1'b0;
    end else if (take && !stopped) begin
      hunt_window <= hunt_window_next;
      byte_position <= pos_inc;
      parse_phase <= parse_phase_next;
      skip_count <= skip_count_next;
      size_left <= size_left_next;
      header_left <= header_left_next;
      pts_accum <= pts_accum_next;
      dts_accum <= dts_accum_next;
      current_id <= current_id_next;
      sub_id <= sub_id_next;
      start_position <= start_position_next;
      stopped <= stopped_next;
      stamp_m1 <= m1_next;
      stamp_m0 <= m0_next;
      stamp_total <= stamp_total_next;
      is_mpeg1 <= is_mpeg1_next;
      got_pts <= got_pts_next;
      got_dts <= got_dts_next;
      sel_flag <= sel_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take && !stopped && res_valid) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !stopped && res_valid) out_ch.data <= res;
  end

  assign out_ch.valid = out_full;

  `ASSERT_IMPL(a_stall_holds, clk, rst, out_full && !out_ch.ready, !in_ch.ready)
  `ASSERT_NEXT(a_stop_sticks, clk, rst, stopped, stopped)
  `ASSERT_NEXT(a_probe_stops, clk, rst, take && !stopped && res_valid && res.kind == KIND_PROBE,
               stopped)
  `ASSERT_IMPL(a_payload_sel, clk, rst, take && !stopped && res_valid &&
               res.kind == KIND_PAYLOAD, sel_flag && parse_phase == PH_PAYLOAD)
endmodule

// ----- dv/tb_program_stream_pes_demux_unit.sv -----
// Testbench for program_stream_pes_demux_unit: random and directed program streams
// are driven byte by byte and every result beat is checked against a byte-level parser.
// Depends on psd_pkg and the psd_in_if / psd_out_if / psd_cfg_if interfaces.
`timescale 1ns / 100ps
module tb_program_stream_pes_demux_unit;
  import psd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd2;
  localparam int IdleLimit = 20000;

  logic clk;
  logic rst;

  psd_in_if in_ch ();
  psd_out_if out_ch ();
  psd_cfg_if cfg ();

  program_stream_pes_demux_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  // parser mirror
  logic [15:0] sel_code;
  logic [47:0] probe_lim;
  logic [23:0] win;
  logic [47:0] pos;
  logic [3:0] phase;
  logic [15:0] skip;
  logic [16:0] size;
  logic [7:0] hleft;
  logic [32:0] pts_a, dts_a;
  logic [7:0] cur_id, sub;
  logic [47:0] start_pos;
  bit stopped, mp1, gpts, gdts, sel;
  logic [1:0] smode;
  logic [3:0] stot;

  result_t expected_q[$];
  logic [7:0] stream_q[$];
  int errors;
  int idle_cycles;
  bit burst;
  bit in_held;
  int in_gap, out_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic mirror_reset();
    sel_code = 16'h00E0; probe_lim = '0; win = 24'hFFFFFF; pos = '0; phase = PH_HUNT;
    skip = '0; size = '0; hleft = '0; pts_a = '0; dts_a = '0; cur_id = '0; sub = 8'hFF;
    start_pos = '0; stopped = 0; mp1 = 0; gpts = 0; gdts = 0; sel = 0; smode = '0;
    stot = '0;
  endtask

  task automatic to_hunt();
    phase = PH_HUNT;
    win = 24'hFFFFFF;
  endtask

  task automatic take_size(input int n);
    if (!size[16]) begin
      if (n > size) size = 17'h10000;
      else size = size - 17'(n);
    end
  endtask

  function automatic logic [32:0] stamp_bits(input int j, input logic [7:0] b);
    case (j)
      0: stamp_bits = 33'(b[3:1]) << 30;
      1: stamp_bits = 33'(b) << 22;
      2: stamp_bits = 33'(b[7:1]) << 15;
      3: stamp_bits = 33'(b) << 7;
      default: stamp_bits = 33'(b[7:1]);
    endcase
  endfunction

  task automatic close_header(output bit got, output result_t r);
    logic [15:0] code;
    r = '0;
    got = 0;
    if (size[16] || size == 0 || size > MaxPayload) begin
      to_hunt();
    end else begin
      code = (cur_id == 8'hBD) ? {8'hFF, sub} : {8'h00, cur_id};
      sel = (code == sel_code);
      r.kind = KIND_HEADER;
      r.stream_code = code;
      r.is_selected = sel;
      r.payload_length = size[15:0];
      r.has_pts = gpts;
      r.pts = gpts ? pts_a : '0;
      r.has_dts = gdts;
      r.dts = gdts ? dts_a : '0;
      r.packet_offset = start_pos;
      phase = PH_PAYLOAD;
      got = 1;
    end
  endtask

  task automatic end_fields(output bit got, output result_t r);
    r = '0;
    got = 0;
    if (mp1) begin
      take_size(1);
      close_header(got, r);
    end else if (cur_id == 8'hBD && (size[16] || size > 5)) begin
      phase = PH_SUBID;
    end else begin
      close_header(got, r);
    end
  endtask

  task automatic go_tail(output bit got, output result_t r);
    r = '0;
    got = 0;
    if (hleft != 0) phase = PH_HSKIP;
    else end_fields(got, r);
  endtask

  task automatic mpeg1_code(input logic [7:0] c, output bit got, output result_t r);
    logic [3:0] m;
    m = c[7:4];
    r = '0;
    got = 0;
    if (m == 1) begin
      to_hunt();
    end else if (m == 2 || m == 3) begin
      take_size(m == 2 ? 4 : 9);
      pts_a = stamp_bits(0, c);
      stot = 5;
      skip = 1;
      hleft = (m == 3) ? 8'd5 : 8'd0;
      phase = PH_STAMP;
    end else begin
      hleft = 0;
      go_tail(got, r);
    end
  endtask

  task automatic demux_byte(input logic [7:0] b, output bit got, output result_t r);
    logic [7:0] s;
    int extra;
    r = '0;
    got = 0;
    if (stopped) return;
    pos = pos + 1;
    case (phase)
      PH_HUNT: begin
        if (win != 24'h000001) begin
          win = {win[15:0], b};
        end else begin
          win = 24'hFFFFFF;
          if (probe_lim != 0 && pos > probe_lim) begin
            stopped = 1;
            r.kind = KIND_PROBE;
            got = 1;
          end else begin
            cur_id = b;
            start_pos = pos - 4;
            if (b == 8'hBA) begin
              skip = 8;
              phase = PH_SKIP;
            end else if (b == 8'hBE || b == 8'hBB) begin
              phase = PH_OOB_HI;
            end else if ((b >= 8'hC0 && b < 8'hC9) || (b >= 8'hE0 && b < 8'hE9) ||
                         (b >= 8'h20 && b < 8'h29) || b == 8'hBD || b == 8'hBF) begin
              sub = 8'hFF; pts_a = '0; dts_a = '0; gpts = 0; gdts = 0; mp1 = 0;
              hleft = 0;
              phase = PH_LEN_HI;
            end
          end
        end
      end
      PH_SKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) to_hunt();
      end
      PH_OOB_HI: begin
        skip = {b, 8'h00};
        phase = PH_OOB_LO;
      end
      PH_OOB_LO: begin
        skip[7:0] = skip[7:0] | b;
        if (skip == 0) to_hunt();
        else phase = PH_SKIP;
      end
      PH_LEN_HI: begin
        size = {1'b0, b, 8'h00};
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        size[7:0] = size[7:0] | b;
        if (cur_id == 8'hBF) close_header(got, r);
        else phase = PH_STUFF;
      end
      PH_STUFF: begin
        if (b == 8'hFF) begin
          take_size(1);
        end else if (b[7:6] == 2'b10) begin
          phase = PH_M2_FLAGS;
        end else begin
          mp1 = 1;
          if (b[7:6] == 2'b01) begin
            take_size(2);
            phase = PH_STD1;
          end else begin
            mpeg1_code(b, got, r);
          end
        end
      end
      PH_STD1: phase = PH_STD2;
      PH_STD2: mpeg1_code(b, got, r);
      PH_M2_FLAGS: begin
        smode = b[7:6];
        phase = PH_M2_HLEN;
      end
      PH_M2_HLEN: begin
        take_size(3 + b);
        if (smode == 1) begin
          to_hunt();
        end else if ((smode == 2 && b >= 5) || (smode == 3 && b >= 10)) begin
          stot = (smode == 2) ? 4'd5 : 4'd10;
          hleft = b - 8'(stot);
          skip = 0;
          phase = PH_STAMP;
        end else begin
          hleft = b;
          go_tail(got, r);
        end
      end
      PH_STAMP: begin
        if (skip < 5) pts_a = pts_a | stamp_bits(skip, b);
        else dts_a = dts_a | stamp_bits(skip - 5, b);
        skip++;
        if (skip >= stot) begin
          gpts = 1;
          gdts = (stot == 10);
          skip = 0;
          go_tail(got, r);
        end
      end
      PH_HSKIP: begin
        if (hleft > 0) hleft--;
        if (hleft == 0) end_fields(got, r);
      end
      PH_SUBID: begin
        s = b;
        extra = 0;
        if (s >= 8'h88 && s <= 8'h8B) s = s - 8'h48;
        else if (s >= 8'h80 && s <= 8'h87) s = s - 8'h80;
        else if (s >= 8'hA0 && s <= 8'hA7) extra = 3;
        else if (!(s >= 8'h20 && s <= 8'h27)) s = 8'hFF;
        if (s > 8'h26 || s < 8'h20) extra += 3;
        take_size(extra + 1);
        sub = s;
        if (extra == 0) begin
          close_header(got, r);
        end else begin
          skip = 16'(extra);
          phase = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (skip > 0) skip--;
        if (skip == 0) close_header(got, r);
      end
      default: begin
        if (size > 0) size--;
        if (size == 0) to_hunt();
        if (sel) begin
          r.kind = KIND_PAYLOAD;
          r.payload_byte = b;
          r.last_of_packet = (size == 0);
          got = 1;
        end
      end
    endcase
  endtask

  task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, nm, e, a);
    end
  endtask

  // monitor and scoreboard
  always @(posedge clk) begin
    bit got;
    result_t r, e;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        r = out_ch.data;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: actual %0h", $time, r);
        end else begin
          e = expected_q.pop_front();
          check_field("kind", e.kind, r.kind);
          check_field("payload_byte", e.payload_byte, r.payload_byte);
          check_field("stream_code", e.stream_code, r.stream_code);
          check_field("is_selected", e.is_selected, r.is_selected);
          check_field("payload_length", e.payload_length, r.payload_length);
          check_field("has_pts", e.has_pts, r.has_pts);
          check_field("pts", e.pts, r.pts);
          check_field("has_dts", e.has_dts, r.has_dts);
          check_field("dts", e.dts, r.dts);
          check_field("packet_offset", e.packet_offset, r.packet_offset);
          check_field("last_of_packet", e.last_of_packet, r.last_of_packet);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        demux_byte(in_ch.data_byte, got, r);
        if (got) expected_q.push_back(r);
      end
      in_held = in_ch.valid && !in_ch.ready;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == 2'(REG_SELECTED)) sel_code = cfg.value[15:0];
        else if (cfg.index == 2'(REG_PROBE)) probe_lim = cfg.value;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg.valid && cfg.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb_program_stream_pes_demux_unit: errors");
          $finish;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // byte driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_held) begin
      if ($urandom_range(199) == 0) burst = !burst;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= stream_q.pop_front();
        in_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  task automatic push_stamp(input logic [3:0] top, input logic [32:0] v, inout logic [7:0] q[$]);
    q.push_back({top, v[32:30], 1'b1});
    q.push_back(v[29:22]);
    q.push_back({v[21:15], 1'b1});
    q.push_back(v[14:7]);
    q.push_back({v[6:0], 1'b1});
  endtask

  function automatic logic [32:0] rand_stamp();
    case ($urandom_range(5))
      0: return '1;
      1: return '0;
      default: return {1'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] rand_id();
    case ($urandom_range(5))
      0: return 8'hC0 + 8'($urandom_range(8));
      1: return 8'hE0 + 8'($urandom_range(8));
      2: return 8'h20 + 8'($urandom_range(8));
      3: return 8'hBF;
      default: return 8'hBD;
    endcase
  endfunction

  // style: 0 random, 1 m2 bare, 2 m2 pts, 3 m2 pts+dts, 4 m2 forbidden flags,
  // 5 m1 bare, 6 m1 std+pts, 7 m1 pts+dts
  task automatic gen_pes(input logic [7:0] id, input int style);
    logic [7:0] body[$];
    logic [7:0] st[$];
    logic [7:0] s;
    int n, len, hlen, mode, k;
    if (style == 0) style = $urandom_range(7, 1);
    if (id != 8'hBF) begin
      k = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
      repeat (k) body.push_back(8'hFF);
      if (style <= 4) begin
        mode = (style == 1) ? 0 : (style == 2) ? 2 : (style == 3) ? 3 : 1;
        body.push_back({2'b10, 6'($urandom)});
        body.push_back({2'(mode), 6'($urandom)});
        if (mode >= 2) push_stamp(mode == 3 ? 4'h3 : 4'h2, rand_stamp(), st);
        if (mode == 3) push_stamp(4'h1, rand_stamp(), st);
        hlen = st.size() + $urandom_range(3);
        if ($urandom_range(9) == 0) hlen = $urandom_range(12);
        body.push_back(8'(hlen));
        for (int i = 0; i < hlen; i++) body.push_back(i < st.size() ? st[i] : 8'($urandom));
        if (id == 8'hBD) begin
          case ($urandom_range(4))
            0: s = 8'h80 + 8'($urandom_range(7));
            1: s = 8'h88 + 8'($urandom_range(3));
            2: s = 8'h20 + 8'($urandom_range(7));
            3: s = 8'hA0 + 8'($urandom_range(7));
            default: s = 8'($urandom);
          endcase
          body.push_back(s);
          k = (s >= 8'h20 && s <= 8'h26) || (s >= 8'h80 && s <= 8'h87) ? 0 :
              (s >= 8'hA0 && s <= 8'hA7) ? 6 : 3;
          repeat (k) body.push_back(8'($urandom));
        end
      end else begin
        if (style == 6 || $urandom_range(3) == 0) begin
          body.push_back({2'b01, 6'($urandom)});
          body.push_back(8'($urandom));
        end
        if (style == 5) begin
          body.push_back($urandom_range(9) == 0 ? {4'h1, 4'($urandom)} : 8'h0F);
        end else begin
          push_stamp(style == 7 ? 4'h3 : 4'h2, rand_stamp(), body);
          if (style == 7) push_stamp(4'h1, rand_stamp(), body);
        end
      end
    end
    k = $urandom_range(19);
    n = (k == 0) ? 0 : (k == 1) ? $urandom_range(200, 40) : $urandom_range(16, 1);
    repeat (n) body.push_back(8'($urandom));
    len = body.size();
    if ($urandom_range(11) == 0) len = $urandom_range(300);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h01);
    stream_q.push_back(id);
    stream_q.push_back(8'(len >> 8));
    stream_q.push_back(8'(len));
    foreach (body[i]) stream_q.push_back(body[i]);
  endtask

  task automatic gen_other(input int what);
    int n;
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h01);
    case (what)
      0: begin
        stream_q.push_back(8'hBA);
        repeat (8) stream_q.push_back(8'($urandom));
      end
      1: begin
        n = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
        stream_q.push_back($urandom_range(1) ? 8'hBE : 8'hBB);
        stream_q.push_back(8'(n >> 8));
        stream_q.push_back(8'(n));
        repeat (n) stream_q.push_back(8'($urandom));
      end
      default: begin
        stream_q.push_back(8'($urandom));
        repeat ($urandom_range(6)) stream_q.push_back(8'($urandom));
      end
    endcase
  endtask

  task automatic gen_random(input int nbytes);
    int target;
    target = stream_q.size() + nbytes;
    while (stream_q.size() < target) begin
      case ($urandom_range(9))
        0: gen_other(0);
        1: gen_other(1);
        2: gen_other(2);
        default: gen_pes(rand_id(), 0);
      endcase
    end
  endtask

  task automatic settle();
    while (stream_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.value <= v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst = 0;
    in_held = 0;
    in_gap = 0;
    out_gap = 0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.value = '0;
    mirror_reset();
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: every packet form, with the default selection
    gen_other(0);
    gen_other(1);
    for (int s = 1; s <= 7; s++) gen_pes(8'hE0, s);
    gen_pes(8'hBF, 1);
    gen_pes(8'hBD, 2);
    gen_pes(8'hC8, 3);
    gen_other(2);
    gen_random(300);
    settle();

    write_reg(2'(REG_SELECTED), 16'hFF20);
    write_reg(2'(REG_PROBE), 48'hFFFF_FFFF_FFFF);
    write_reg(REG_UNUSED, 48'h1234);
    gen_random(300);
    settle();

    write_reg(2'(REG_SELECTED), 16'h00BF);
    write_reg(2'(REG_PROBE), 48'h0);
    gen_random(300);
    settle();

    write_reg(2'(REG_SELECTED), 16'h0000);
    gen_random(150);
    settle();
    write_reg(2'(REG_SELECTED), 16'hFFFF);
    gen_random(150);
    settle();

    write_reg(2'(REG_SELECTED), 16'h00C0);
    write_reg(2'(REG_PROBE), pos + 48'd200);
    gen_random(400);
    settle();

    if (errors == 0) begin
      $display("tb_program_stream_pes_demux_unit: clean");
    end else begin
      $display("tb_program_stream_pes_demux_unit: errors");
    end
    $finish;
  end
endmodule
